/* rtl/b2b_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2b_pkg: shared types and constants for the blake2b hash engine
// holds the payload structs, initial values, message schedule and mix pattern
// ----------------------------------------------------------------------------
package b2b_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [3:0]  digest_valid_bytes;
    logic        digest_last;
  } out_beat_t;

  localparam logic [63:0] PARAM_CONST = 64'h0000_0000_0101_0000;

  function automatic logic [63:0] iv_word(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0:    r = 64'h6a09e667f3bcc908;
      3'd1:    r = 64'hbb67ae8584caa73b;
      3'd2:    r = 64'h3c6ef372fe94f82b;
      3'd3:    r = 64'ha54ff53a5f1d36f1;
      3'd4:    r = 64'h510e527fade682d1;
      3'd5:    r = 64'h9b05688c2b3e6c1f;
      3'd6:    r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  // message schedule, one 64-bit row of nibbles per round mod 10, entry 0 in low nibble
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] k);
    logic [63:0] row;
    case (rnd)
      4'd0:    row = 64'hfedcba9876543210;
      4'd1:    row = 64'h357b20c16df984ae;
      4'd2:    row = 64'h491763eadf250c8b;
      4'd3:    row = 64'h8f04a562ebcd1397;
      4'd4:    row = 64'hd386cb1efa427509;
      4'd5:    row = 64'h91ef57d438b0a6c2;
      4'd6:    row = 64'hb8293670a4def15c;
      4'd7:    row = 64'ha2684f05931ce7bd;
      4'd8:    row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[{k, 2'b00} +: 4];
  endfunction

  // working vector indexes a,b,c,d for each of the eight mixes
  function automatic logic [15:0] mix_sel(input logic [2:0] g);
    logic [15:0] r;
    case (g)
      3'd0:    r = 16'hc840;
      3'd1:    r = 16'hd951;
      3'd2:    r = 16'hea62;
      3'd3:    r = 16'hfb73;
      3'd4:    r = 16'hfa50;
      3'd5:    r = 16'hcb61;
      3'd6:    r = 16'hd872;
      default: r = 16'he943;
    endcase
    return r;
  endfunction

endpackage

/* rtl/blake2b_hash_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blake2b_hash_engine: unkeyed blake2b hash over a 64-bit word stream
// buffers 128-byte blocks, compresses with one shared mix unit, emits digest
// ----------------------------------------------------------------------------
// One beat is taken at a time. A beat's valid bytes are packed into the block
// buffer one byte a cycle while no compression is due, then the beat is closed;
// in_ready stays low from the accepting edge until the beat is closed.
// When a byte arrives while the buffer is full, the buffer is first compressed:
// 12 rounds of 8 mixes run through one shared half-mix unit (three 64-bit adds,
// two xors, two rotates), each mix as two halves, after a load step and before
// a feed-forward step. A last beat pads and compresses with the final flag, then
// the digest leaves as ceil(digest_bytes/8) beats through a registered output
// stage. After the digest, and after any write to cfg_digest_bytes,
// the engine re-initializes. cfg_digest_bytes of 0 acts as 1, above 64 acts as 64.
module blake2b_hash_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b2b_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output b2b_pkg::out_beat_t   out_data,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_digest_bytes
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PACK  = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_MIX   = 7'b0001000,
    ST_FOLD  = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_INIT  = 7'b1000000
  } state_t;

  state_t       state_r, state_nxt;
  logic [6:0]   dbytes_r;
  logic [63:0]  h_r [8];
  logic [63:0]  m_r [16];
  logic [63:0]  v_r [16];
  logic [127:0] cnt_r;
  logic [7:0]   fill_r;
  logic [63:0]  word_r;
  logic [3:0]   nb_r;
  logic         last_r;
  logic         final_r;
  logic [3:0]   rnd_r;
  logic [2:0]   mix_r;
  logic         half_r;
  logic [2:0]   owi_r;
  logic         ov_r;
  b2b_pkg::out_beat_t od_r;

  // effective digest length
  logic [6:0] elen;
  always_comb begin
    if (dbytes_r == 7'd0) elen = 7'd1;
    else if (dbytes_r > 7'd64) elen = 7'd64;
    else elen = dbytes_r;
  end
  logic [2:0] lastw;
  assign lastw = 3'((elen - 7'd1) >> 3);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // next digest beat can enter the output stage
  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && (!ov_r || out_ready);

  // shared half-mix unit
  logic [15:0] sel;
  logic [3:0]  ia, ib, ic, id;
  logic [3:0]  rmod;
  logic [63:0] mw, na, nd0, nd, nc, nb0, nbv;
  assign sel  = b2b_pkg::mix_sel(mix_r);
  assign ia   = sel[3:0];
  assign ib   = sel[7:4];
  assign ic   = sel[11:8];
  assign id   = sel[15:12];
  assign rmod = (rnd_r >= 4'd10) ? rnd_r - 4'd10 : rnd_r;
  assign mw   = m_r[b2b_pkg::sigma(rmod, {mix_r, half_r})];
  assign na   = v_r[ia] + v_r[ib] + mw;
  assign nd0  = v_r[id] ^ na;
  assign nd   = half_r ? {nd0[15:0], nd0[63:16]} : {nd0[31:0], nd0[63:32]};
  assign nc   = v_r[ic] + nd;
  assign nb0  = v_r[ib] ^ nc;
  assign nbv  = half_r ? {nb0[62:0], nb0[63]} : {nb0[23:0], nb0[63:24]};

  logic buf_full;
  assign buf_full = (fill_r == 8'd128);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PACK;
      ST_PACK: begin
        if (nb_r != 4'd0) begin
          if (buf_full) state_nxt = ST_LOAD;
        end else if (last_r) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: state_nxt = ST_MIX;
      ST_MIX:  if (rnd_r == 4'd11 && mix_r == 3'd7 && half_r) state_nxt = ST_FOLD;
      ST_FOLD: state_nxt = final_r ? ST_EMIT : ST_PACK;
      ST_EMIT: if (!ov_r || out_ready) begin
        if (owi_r == lastw) state_nxt = ST_INIT;
      end
      ST_INIT: if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      dbytes_r <= 7'd64;
      ov_r     <= 1'b0;
      fill_r   <= 8'd0;
      cnt_r    <= '0;
      owi_r    <= '0;
    end else begin
      // config write re-initializes; the user must write only while idle, unenforced
      state_r <= cfg_we ? ST_INIT : state_nxt;
      if (cfg_we) dbytes_r <= cfg_digest_bytes;
      if (emit_go) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            word_r <= in_data.message_word;
            nb_r   <= (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
            last_r <= in_data.last_word;
          end
        end
        ST_PACK: begin
          if (nb_r != 4'd0) begin
            if (buf_full) begin
              cnt_r   <= cnt_r + 128'd128;
              final_r <= 1'b0;
            end else begin
              m_r[fill_r[6:3]][{fill_r[2:0], 3'b000} +: 8] <= word_r[7:0];
              word_r <= word_r >> 8;
              nb_r   <= nb_r - 4'd1;
              fill_r <= fill_r + 8'd1;
            end
          end else if (last_r) begin
            cnt_r   <= cnt_r + 128'(fill_r);
            final_r <= 1'b1;
            // zero-pad unused bytes
            for (int i = 0; i < 128; i++) begin
              if (8'(i) >= fill_r) m_r[4'(i >> 3)][{3'(i), 3'b000} +: 8] <= 8'h00;
            end
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 8; i++) v_r[4'(i)] <= h_r[3'(i)];
          v_r[8]  <= b2b_pkg::iv_word(3'd0);
          v_r[9]  <= b2b_pkg::iv_word(3'd1);
          v_r[10] <= b2b_pkg::iv_word(3'd2);
          v_r[11] <= b2b_pkg::iv_word(3'd3);
          v_r[12] <= b2b_pkg::iv_word(3'd4) ^ cnt_r[63:0];
          v_r[13] <= b2b_pkg::iv_word(3'd5) ^ cnt_r[127:64];
          v_r[14] <= final_r ? ~b2b_pkg::iv_word(3'd6) : b2b_pkg::iv_word(3'd6);
          v_r[15] <= b2b_pkg::iv_word(3'd7);
          rnd_r   <= '0;
          mix_r   <= '0;
          half_r  <= 1'b0;
        end
        ST_MIX: begin
          v_r[ia] <= na;
          v_r[id] <= nd;
          v_r[ic] <= nc;
          v_r[ib] <= nbv;
          half_r  <= ~half_r;
          if (half_r) begin
            mix_r <= mix_r + 3'd1;
            if (mix_r == 3'd7) rnd_r <= rnd_r + 4'd1;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[3'(i)] <= h_r[3'(i)] ^ v_r[4'(i)] ^ v_r[4'(i + 8)];
          end
          if (!final_r) fill_r <= 8'd0;
          owi_r <= '0;
        end
        ST_EMIT: begin
          if (emit_go) begin
            logic [6:0] left;
            left = elen - {owi_r, 3'b000};
            od_r.digest_last <= (owi_r == lastw);
            if (left >= 7'd8) begin
              od_r.digest_valid_bytes <= 4'd8;
              od_r.digest_word        <= h_r[owi_r];
            end else begin
              od_r.digest_valid_bytes <= 4'(left);
              od_r.digest_word <= h_r[owi_r] & ((64'd1 << {left[2:0], 3'b000}) - 64'd1);
            end
            owi_r <= owi_r + 3'd1;
          end
        end
        ST_INIT: begin
          for (int i = 1; i < 8; i++) h_r[3'(i)] <= b2b_pkg::iv_word(3'(i));
          h_r[0] <= b2b_pkg::iv_word(3'd0) ^ b2b_pkg::PARAM_CONST ^ 64'(elen);
          cnt_r  <= '0;
          fill_r <= 8'd0;
        end
        default: ;
      endcase
    end
  end

endmodule
